@@ sv/swc_pkg.sv @@
// Types and constants shared by the sensor window conditioner.
package swc_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = SAMPLE_W + 1;
  localparam int unsigned AGE_W    = 7;
  localparam int unsigned AGE_N    = 1 << AGE_W;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FORCE_W  = 7;
  localparam int unsigned ENTRY_W  = 2 * BYTE_W + FORCE_W;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Force: sum / 400 as multiply by reciprocal, exact for sums below the saturation point.
  localparam int unsigned FORCE_RECIP_W = 18;
  localparam logic [FORCE_RECIP_W-1:0] FORCE_RECIP = 18'd167773;
  localparam int unsigned FORCE_SHIFT   = 26;
  localparam logic signed [SUM_W-1:0] FORCE_SAT = 17'sd51200;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] accel_sample;
    logic signed [SAMPLE_W-1:0] rotate_sample;
    logic signed [SAMPLE_W-1:0] force_sample;
    logic [AGE_W-1:0]           read_age;
  } swc_in_t;

  typedef struct packed {
    logic                     was_read;
    logic signed [BYTE_W-1:0] accel_byte;
    logic signed [BYTE_W-1:0] rotate_byte;
    logic [FORCE_W-1:0]       force_byte;
  } swc_out_t;

endpackage

@@ sv/sensor_window_conditioner.sv @@
// Sensor window conditioner: averaging, scaling, clamping and a circular window store.
//
// Each input word is either a sample triple, which is averaged with the previous
// sample, scaled, clamped, written into a circular window of WINDOW_DEPTH entries
// and returned, or a read, which returns the window entry at the given age (age 0
// is the oldest entry, the age wraps modulo WINDOW_DEPTH). The block takes one
// word per cycle unless output back-pressure stalls it, and passes it through its stages in order: one stage
// forms the sums and window address, one stage does the scaling and the single
// access to the window memory (one write or one read per word), and an output
// register holds the result. Entries never written read as zero through a fill
// count, so no clearing pass is needed after reset.
module sensor_window_conditioner
  import swc_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  swc_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output swc_out_t out_word_o
);

  localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PW = SAMPLE_W + FORCE_RECIP_W;

  logic                    en1, en2, adv_out, in_fire;

  logic signed [SAMPLE_W-1:0] prev_a_q, prev_r_q, prev_f_q;
  logic [IW-1:0]           slot_q;
  logic [FW-1:0]           fill_q;

  logic                    s1_v_q, s1_cmd_q, s1_hit_q;
  logic signed [SUM_W-1:0] s1_sa_q, s1_sr_q, s1_sf_q;
  logic [IW-1:0]           s1_addr_q;

  logic                    s2_v_q, s2_cmd_q, s2_hit_q;
  logic [ENTRY_W-1:0]      s2_entry_q;
  logic [ENTRY_W-1:0]      rdata_q;

  logic                    out_v_q;
  swc_out_t                out_q;

  logic [ENTRY_W-1:0]      mem_q [WINDOW_DEPTH];

  logic [IW-1:0]           age_mod [AGE_N];
  logic [IW:0]             idx_sum;
  logic [IW-1:0]           rd_idx;
  logic                    rd_hit;

  logic signed [SUM_W-1:0] acc_adj, acc_div, rot_adj, rot_div;
  logic signed [BYTE_W-1:0] acc_byte, rot_byte;
  logic [PW-1:0]           f_prod;
  logic [FORCE_W-1:0]      f_byte;
  logic [ENTRY_W-1:0]      entry;
  logic [ENTRY_W-1:0]      res_entry;

  for (genvar g = 0; g < AGE_N; g++) begin : g_age
    localparam int unsigned AgeRed = g % WINDOW_DEPTH;
    assign age_mod[g] = IW'(AgeRed);
  end

  // Handshake and stage enables
  assign adv_out     = !out_v_q || out_ready_i;
  assign en2         = !s2_v_q || adv_out;
  assign en1         = !s1_v_q || en2;
  assign in_ready_o  = en1;
  assign in_fire     = in_valid_i && en1;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  // Read address: (slot + age) mod depth
  always_comb begin
    idx_sum = {1'b0, age_mod[in_word_i.read_age]} + {1'b0, slot_q};
    if (idx_sum >= (IW+1)'(WINDOW_DEPTH)) begin
      idx_sum = idx_sum - (IW+1)'(WINDOW_DEPTH);
    end
    rd_idx = idx_sum[IW-1:0];
    rd_hit = (fill_q == FW'(WINDOW_DEPTH)) || (FW'(rd_idx) < fill_q);
  end

  // Scaling and clamping
  always_comb begin
    acc_adj = s1_sa_q + (s1_sa_q[SUM_W-1] ? 17'sd127 : 17'sd0);
    acc_div = acc_adj >>> 7;
    if (acc_div < -17'sd128) begin
      acc_byte = -8'sd128;
    end else if (acc_div > 17'sd127) begin
      acc_byte = 8'sd127;
    end else begin
      acc_byte = acc_div[BYTE_W-1:0];
    end
    rot_adj  = s1_sr_q + (s1_sr_q[SUM_W-1] ? 17'sd4095 : 17'sd0);
    rot_div  = rot_adj >>> 12;
    rot_byte = rot_div[BYTE_W-1:0];
    f_prod   = PW'(s1_sf_q[SAMPLE_W-1:0]) * PW'(FORCE_RECIP);
    if (s1_sf_q[SUM_W-1]) begin
      f_byte = '0;
    end else if (s1_sf_q >= FORCE_SAT) begin
      f_byte = '1;
    end else begin
      f_byte = f_prod[FORCE_SHIFT +: FORCE_W];
    end
    entry = {acc_byte, rot_byte, f_byte};
  end

  // Input side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q <= '0;
      prev_r_q <= '0;
      prev_f_q <= '0;
      slot_q   <= '0;
      fill_q   <= '0;
    end else if (in_fire && in_word_i.cmd == CMD_SAMPLE) begin
      prev_a_q <= in_word_i.accel_sample;
      prev_r_q <= in_word_i.rotate_sample;
      prev_f_q <= in_word_i.force_sample;
      if (slot_q == IW'(WINDOW_DEPTH - 1)) begin
        slot_q <= '0;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
      if (fill_q != FW'(WINDOW_DEPTH)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= in_valid_i;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (adv_out) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_cmd_q  <= in_word_i.cmd;
      s1_sa_q   <= SUM_W'(in_word_i.accel_sample) + SUM_W'(prev_a_q);
      s1_sr_q   <= SUM_W'(in_word_i.rotate_sample) + SUM_W'(prev_r_q);
      s1_sf_q   <= SUM_W'(in_word_i.force_sample) + SUM_W'(prev_f_q);
      s1_addr_q <= (in_word_i.cmd == CMD_READ) ? rd_idx : slot_q;
      s1_hit_q  <= rd_hit;
    end
    if (en2) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_hit_q   <= s1_hit_q;
      s2_entry_q <= entry;
    end
    if (adv_out) begin
      out_q.was_read    <= s2_cmd_q;
      out_q.accel_byte  <= res_entry[ENTRY_W-1 -: BYTE_W];
      out_q.rotate_byte <= res_entry[FORCE_W +: BYTE_W];
      out_q.force_byte  <= res_entry[FORCE_W-1:0];
    end
  end

  always_comb begin
    if (s2_cmd_q == CMD_READ) begin
      res_entry = s2_hit_q ? rdata_q : '0;
    end else begin
      res_entry = s2_entry_q;
    end
  end

  // Window memory: one access per word
  always_ff @(posedge clk_i) begin
    if (en2 && s1_v_q) begin
      if (s1_cmd_q == CMD_SAMPLE) begin
        mem_q[s1_addr_q] <= entry;
      end else begin
        rdata_q <= mem_q[s1_addr_q];
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for the sensor window conditioner: random sample and read words against a scoreboard.
module tb_top;
  import swc_pkg::*;

  localparam int unsigned DEPTH       = 128;
  localparam int unsigned RANDOM_N    = 2000;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic    drain;
    swc_in_t word;
  } stim_t;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_COIN,
    FLOW_SPARSE,
    FLOW_STRIDE
  } flow_e;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  swc_in_t  in_word = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  swc_out_t out_word;

  stim_t    pending[$];
  swc_out_t results_due[$];
  swc_out_t window_copy[DEPTH];

  logic signed [SAMPLE_W-1:0] last_accel;
  logic signed [SAMPLE_W-1:0] last_rotate;
  logic signed [SAMPLE_W-1:0] last_force;
  int unsigned                next_slot;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic        launch;
  stim_t       stim;
  flow_e       flow_mode = FLOW_FREE;
  int unsigned flow_left = 0;
  int unsigned stride_phase = 0;
  logic        ready_next;
  swc_out_t    want;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  sensor_window_conditioner #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  always #5 clk = ~clk;

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic swc_out_t condition_word(swc_in_t w);
    swc_out_t res;
    int       sum_a;
    int       sum_r;
    int       sum_f;
    int       ca;
    int       cr;
    int       cf;
    res = '0;
    if (w.cmd == CMD_READ) begin
      res = window_copy[(next_slot + int'(w.read_age)) % DEPTH];
      res.was_read = 1'b1;
    end else begin
      sum_a = int'($signed(w.accel_sample)) + int'(last_accel);
      sum_r = int'($signed(w.rotate_sample)) + int'(last_rotate);
      sum_f = int'($signed(w.force_sample)) + int'(last_force);
      ca = clamp_to(sum_a / 128, -128, 127);
      cr = clamp_to(sum_r / 4096, -128, 127);
      cf = clamp_to(sum_f / 400, 0, 127);
      last_accel  = w.accel_sample;
      last_rotate = w.rotate_sample;
      last_force  = w.force_sample;
      res.was_read    = 1'b0;
      res.accel_byte  = ca[BYTE_W-1:0];
      res.rotate_byte = cr[BYTE_W-1:0];
      res.force_byte  = cf[FORCE_W-1:0];
      window_copy[next_slot] = res;
      next_slot = (next_slot + 1) % DEPTH;
    end
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1: v = int'($urandom_range(0, 1200)) - 600;
      2: v = int'($urandom_range(25000, 26200)) * ($urandom_range(0, 1) ? 1 : -1);
      3: v = int'($urandom_range(0, 8400)) - 4200;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic add_sample(int a, int r, int f, logic drain);
    stim_t s;
    s.drain              = drain;
    s.word.cmd           = CMD_SAMPLE;
    s.word.accel_sample  = a[SAMPLE_W-1:0];
    s.word.rotate_sample = r[SAMPLE_W-1:0];
    s.word.force_sample  = f[SAMPLE_W-1:0];
    s.word.read_age      = AGE_W'($urandom_range(0, AGE_N - 1));
    pending.push_back(s);
  endtask

  task automatic add_read(int age, logic drain);
    stim_t s;
    s.drain              = drain;
    s.word.cmd           = CMD_READ;
    s.word.accel_sample  = SAMPLE_W'($urandom);
    s.word.rotate_sample = SAMPLE_W'($urandom);
    s.word.force_sample  = SAMPLE_W'($urandom);
    s.word.read_age      = age[AGE_W-1:0];
    pending.push_back(s);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        results_due.push_back(condition_word(in_word));
      end
      if (!in_valid || in_ready) begin
        launch = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && results_due.size() != 0)) begin
          stim   = pending.pop_front();
          launch = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
        in_valid <= launch;
        if (launch) begin
          in_word <= stim.word;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t unexpected word: expected none, got %p", $time, out_word);
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (out_word.was_read !== want.was_read) begin
            $display("%0t was_read expected %0d got %0d", $time, want.was_read,
                     out_word.was_read);
            error_count++;
          end
          if (out_word.accel_byte !== want.accel_byte) begin
            $display("%0t accel_byte expected %0d got %0d", $time, want.accel_byte,
                     out_word.accel_byte);
            error_count++;
          end
          if (out_word.rotate_byte !== want.rotate_byte) begin
            $display("%0t rotate_byte expected %0d got %0d", $time, want.rotate_byte,
                     out_word.rotate_byte);
            error_count++;
          end
          if (out_word.force_byte !== want.force_byte) begin
            $display("%0t force_byte expected %0d got %0d", $time, want.force_byte,
                     out_word.force_byte);
            error_count++;
          end
        end
      end
      if (flow_left == 0) begin
        flow_mode = flow_e'($urandom_range(0, 3));
        flow_left = $urandom_range(16, 200);
      end else begin
        flow_left--;
      end
      stride_phase = (stride_phase + 1) % 7;
      case (flow_mode)
        FLOW_FREE:   ready_next = 1'b1;
        FLOW_COIN:   ready_next = 1'($urandom_range(0, 1));
        FLOW_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
        default:     ready_next = (stride_phase < 3);
      endcase
      out_ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int i;
    last_accel  = '0;
    last_rotate = '0;
    last_force  = '0;
    next_slot   = 0;
    for (i = 0; i < DEPTH; i++) begin
      window_copy[i] = '0;
    end

    add_read(0, 1'b0);
    add_read(127, 1'b0);
    add_sample(32767, 32767, 32767, 1'b0);
    add_sample(32767, 32767, 32767, 1'b0);
    add_sample(-32768, -32768, -32768, 1'b0);
    add_sample(-32768, -32768, -32768, 1'b0);
    add_sample(0, 0, 0, 1'b0);
    add_sample(-127, -4095, -399, 1'b0);
    add_sample(127, 4095, 399, 1'b0);
    add_sample(1, 1, 25600, 1'b0);
    add_sample(-129, -4097, 25600, 1'b0);
    add_sample(0, 0, 25599, 1'b0);
    add_sample(255, 8191, 25200, 1'b0);
    add_sample(-256, -8192, 200, 1'b0);
    add_read(0, 1'b1);
    add_read(1, 1'b0);
    add_read(13, 1'b0);
    add_read(114, 1'b0);
    add_read(115, 1'b0);
    add_read(127, 1'b0);
    add_sample(16000, -16000, -200, 1'b0);
    add_read(126, 1'b0);

    for (i = 0; i < RANDOM_N; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        add_sample(int'($signed(pick_sample())), int'($signed(pick_sample())),
                   int'($signed(pick_sample())), i == RANDOM_N / 2);
      end else begin
        add_read($urandom_range(0, AGE_N - 1), i == RANDOM_N / 2);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
